>>> rtl/altw_pkg.sv
// Shared constants and types for the windowed altitude average.
`default_nettype none

package altw_pkg;

  localparam int unsigned WINDOW     = 20;
  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned PCT_W      = 10;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned HALF       = WINDOW / 2;

  // Width of the running sum, also wide enough to hold the sum plus the rounding term.
  localparam int unsigned SUM_W      = $clog2(WINDOW * SAMPLE_MAX + HALF + 1);

  // Division by WINDOW is a multiply by a rounded-up reciprocal and a shift.
  // The shift is large enough that the quotient is exact over the whole sum range.
  localparam int unsigned DIV_SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int unsigned RECIP      = ((1 << DIV_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int unsigned RECIP_W    = SUM_W + 1;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [PCT_W-1:0]    pct_t;

  typedef struct packed {
    logic    valid;
    sample_t mean;
  } mean_stage_t;

endpackage

`default_nettype wire

>>> rtl/altw_cell.sv
// One storage cell of the sample window shift chain.
`default_nettype none

module altw_cell (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic shift_en,
  input  altw_pkg::sample_t  d_in,
  output altw_pkg::sample_t  q_out
);

  altw_pkg::sample_t q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d_in;
    end
  end

  assign q_out = q_r;

endmodule

`default_nettype wire

>>> rtl/altw_mean.sv
// Running window sum and rounded mean stage.
`default_nettype none

module altw_mean (
  input  wire                    logic clk,
  input  wire                    logic rst_n,
  input  wire                    logic accept,
  input  altw_pkg::sample_t      sample,
  input  altw_pkg::sample_t      oldest,
  input  wire                    logic down_ready,
  output logic                   ready,
  output altw_pkg::mean_stage_t  mean_o
);

  logic                          sum_valid_r;
  altw_pkg::sum_t                sum_r;
  altw_pkg::sum_t                sum_nxt;
  logic                          mean_valid_r;
  altw_pkg::sample_t             mean_r;
  logic                          mean_ready;
  logic                          mean_load;
  altw_pkg::sum_t                rounded;
  logic [altw_pkg::PROD_W-1:0]   product;

  assign mean_ready = !mean_valid_r || down_ready;
  assign ready      = !sum_valid_r || mean_ready;
  assign mean_load  = sum_valid_r && mean_ready;

  // The oldest sample leaves the window as the new one enters.
  assign sum_nxt = sum_r - altw_pkg::SUM_W'(oldest) + altw_pkg::SUM_W'(sample);

  assign rounded = sum_r + altw_pkg::SUM_W'(altw_pkg::HALF);
  assign product = altw_pkg::PROD_W'(rounded) * altw_pkg::PROD_W'(altw_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_valid_r  <= 1'b0;
      sum_r        <= '0;
      mean_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        sum_r       <= sum_nxt;
        sum_valid_r <= 1'b1;
      end else if (mean_load) begin
        sum_valid_r <= 1'b0;
      end
      if (mean_ready) begin
        mean_valid_r <= sum_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mean_load) begin
      mean_r <= product[altw_pkg::DIV_SHIFT +: altw_pkg::SAMPLE_W];
    end
  end

  assign mean_o.valid = mean_valid_r;
  assign mean_o.mean  = mean_r;

endmodule

`default_nettype wire

>>> rtl/altw_height.sv
// Baseline capture, height percentage and output register.
`default_nettype none

module altw_height (
  input  wire                    logic clk,
  input  wire                    logic rst_n,
  input  altw_pkg::mean_stage_t  mean_i,
  output logic                   ready,
  output logic                   out_valid,
  input  wire                    logic out_ready,
  output altw_pkg::pct_t         out_height_percent,
  output altw_pkg::sample_t      out_mean_level,
  output logic                   out_baseline_set
);

  logic                            out_valid_r;
  altw_pkg::sample_t               baseline_r;
  altw_pkg::sample_t               baseline_nxt;
  altw_pkg::pct_t                  pct_r;
  altw_pkg::pct_t                  pct_nxt;
  altw_pkg::sample_t               mean_r;
  logic                            take;
  altw_pkg::sample_t               diff;
  logic [altw_pkg::SAMPLE_W:0]     diff_rnd;

  assign ready = !out_valid_r || out_ready;
  assign take  = mean_i.valid && ready;

  assign diff     = baseline_r - mean_i.mean;
  assign diff_rnd = {1'b0, diff} + (altw_pkg::SAMPLE_W + 1)'(4);

  always_comb begin
    baseline_nxt = baseline_r;
    pct_nxt      = pct_r;
    if (baseline_r == '0) begin
      // Capture step: the percentage from before is repeated.
      baseline_nxt = mean_i.mean;
    end else if (mean_i.mean > baseline_r) begin
      pct_nxt = '0;
    end else begin
      pct_nxt = diff_rnd[altw_pkg::SAMPLE_W:3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      baseline_r  <= '0;
      pct_r       <= '0;
    end else begin
      if (take) begin
        out_valid_r <= 1'b1;
        baseline_r  <= baseline_nxt;
        pct_r       <= pct_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mean_r <= mean_i.mean;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_height_percent = pct_r;
  assign out_mean_level     = mean_r;
  assign out_baseline_set   = (baseline_r != '0);

endmodule

`default_nettype wire

>>> rtl/altitude_window_average.sv
// Top level of the windowed altitude average with captured baseline.
//
// One sample enters per item on the in_ channel (in_valid/in_ready) and one
// result leaves per item on the out_ channel (out_valid/out_ready). A result
// carries the rounded mean of the last WINDOW samples, the rounded drop of the
// mean below the captured baseline in units of 8 counts, and a flag that shows
// a baseline has been captured.
// The window is a chain of cells that shifts one place per accepted item;
// the last cell holds the oldest sample, which leaves the running sum.
// An accepted item passes the sum register, then the mean register that
// takes the reciprocal multiply, then the baseline and output register.
// Throughput is one item per cycle while the receiver takes results; each of
// the three stages has its own valid bit, so a stalled output holds its
// result while the earlier stages keep filling.
// When the receiver stalls, in_ready falls once all three stages are full.
// A synchronous reset clears the window, the sum, the baseline, the held
// percentage and all valid bits; the block takes items once reset is released.
`default_nettype none

module altitude_window_average (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_valid,
  output logic               in_ready,
  input  altw_pkg::sample_t  in_sample,
  output logic               out_valid,
  input  wire                logic out_ready,
  output altw_pkg::pct_t     out_height_percent,
  output altw_pkg::sample_t  out_mean_level,
  output logic               out_baseline_set
);

  altw_pkg::sample_t     taps [altw_pkg::WINDOW+1];
  logic                  accept;
  logic                  height_ready;
  altw_pkg::mean_stage_t mean_stage;

  assign accept  = in_valid && in_ready;
  assign taps[0] = in_sample;

  for (genvar i = 0; i < altw_pkg::WINDOW; i++) begin : g_cells
    altw_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (accept),
      .d_in     (taps[i]),
      .q_out    (taps[i+1])
    );
  end

  altw_mean u_mean (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .sample     (in_sample),
    .oldest     (taps[altw_pkg::WINDOW]),
    .down_ready (height_ready),
    .ready      (in_ready),
    .mean_o     (mean_stage)
  );

  altw_height u_height (
    .clk                (clk),
    .rst_n              (rst_n),
    .mean_i             (mean_stage),
    .ready              (height_ready),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_height_percent (out_height_percent),
    .out_mean_level     (out_mean_level),
    .out_baseline_set   (out_baseline_set)
  );

endmodule

`default_nettype wire

>>> rtl/altw_checker.sv
// Port-level assertions for the windowed altitude average, bound to the top level.
`default_nettype none

module altw_checker (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic in_ready,
  input  wire                logic out_valid,
  input  wire                logic out_ready,
  input  altw_pkg::pct_t     out_height_percent,
  input  altw_pkg::sample_t  out_mean_level,
  input  wire                logic out_baseline_set
);

  // A result held back by the receiver keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_height_percent)
      && $stable(out_mean_level) && $stable(out_baseline_set))
    else $error("stalled result changed");

  // No height can be reported before a baseline exists.
  a_no_height_early: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_baseline_set |-> out_height_percent == '0)
    else $error("height reported without baseline");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_height_percent <= altw_pkg::PCT_W'(512))
    else $error("height percent out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result shown right after reset");

  // An empty block never refuses an item.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> in_ready)
    else $error("input not ready after reset");

endmodule

bind altitude_window_average altw_checker u_altw_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_height_percent (out_height_percent),
  .out_mean_level     (out_mean_level),
  .out_baseline_set   (out_baseline_set)
);

`default_nettype wire

>>> tb/tb.sv
// Testbench for the windowed altitude average with captured baseline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    altw_pkg::pct_t    height_percent;
    altw_pkg::sample_t mean_level;
    logic              baseline_set;
  } reading_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  altw_pkg::sample_t in_sample;
  logic              out_valid;
  logic              out_ready;
  altw_pkg::pct_t    out_height_percent;
  altw_pkg::sample_t out_mean_level;
  logic              out_baseline_set;

  altitude_window_average uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_sample          (in_sample),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_height_percent (out_height_percent),
    .out_mean_level     (out_mean_level),
    .out_baseline_set   (out_baseline_set)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Own copy of the altitude state, advanced once per accepted sample.
  altw_pkg::sample_t window_buf [altw_pkg::WINDOW];
  int unsigned       window_pos;
  int unsigned       window_total;
  altw_pkg::sample_t baseline_mem;
  altw_pkg::pct_t    held_height;

  reading_t    pending_readings[$];
  int unsigned tx_gap_max;
  int unsigned rx_stall_max;
  int unsigned err_count;
  int unsigned samples_sent;
  int unsigned readings_seen;
  int unsigned nonzero_heights;
  int unsigned over_baseline;

  function automatic reading_t advance_altitude(input altw_pkg::sample_t s);
    int unsigned avg;
    int unsigned drop;
    reading_t    r;
    window_total = window_total - window_buf[window_pos] + s;
    window_buf[window_pos] = s;
    window_pos = (window_pos == altw_pkg::WINDOW - 1) ? 0 : window_pos + 1;
    avg = (window_total + altw_pkg::WINDOW / 2) / altw_pkg::WINDOW;
    if (baseline_mem == '0) begin
      baseline_mem = altw_pkg::sample_t'(avg);
    end else if (avg > baseline_mem) begin
      held_height = '0;
      over_baseline++;
    end else begin
      drop = baseline_mem - avg;
      held_height = altw_pkg::pct_t'((drop / 4 + 1) / 2);
    end
    if (held_height != '0) nonzero_heights++;
    r.height_percent = held_height;
    r.mean_level     = altw_pkg::sample_t'(avg);
    r.baseline_set   = (baseline_mem != '0);
    return r;
  endfunction

  // Valid stays high across back-to-back items, so it is only lowered before a gap.
  task automatic send_sample(input altw_pkg::sample_t s);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_readings.push_back(advance_altitude(s));
    samples_sent++;
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_readings.size() != 0);
  endtask

  task automatic set_pacing(input int unsigned mode);
    tx_gap_max   = (mode == 1 || mode == 2) ? 18 : 0;
    rx_stall_max = (mode == 1 || mode == 3) ? 18 : 0;
  endtask

  // The first samples keep the mean at zero so no baseline is taken; the
  // full-scale sample then captures a small baseline with the height held.
  task automatic test_startup();
    set_pacing(0);
    send_sample(12'd0);
    send_sample(12'd9);
    send_sample(12'hFFF);
  endtask

  // Full-scale samples push the mean over the baseline; the alternating
  // patterns toggle every sample bit.
  task automatic test_extremes();
    set_pacing(1);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    send_sample(12'h555);
    send_sample(12'hAAA);
    send_sample(12'h001);
    send_sample(12'h800);
    send_sample(12'h7FF);
    send_sample(12'h000);
  endtask

  // Runs long enough to turn the window over at a steady level, so the mean
  // settles low, high, near the baseline or at a random level, with some jitter.
  task automatic test_level_runs();
    int unsigned run_len;
    int unsigned kind;
    int          level;
    int          s;
    for (int run = 0; run < 13; run++) begin
      set_pacing($urandom_range(0, 3));
      kind    = $urandom_range(0, 3);
      run_len = $urandom_range(20, 30);
      case (kind)
        0: level = 0;
        1: level = altw_pkg::SAMPLE_MAX;
        2: level = int'(baseline_mem) + $urandom_range(0, 100) - 60;
        default: level = $urandom_range(0, altw_pkg::SAMPLE_MAX);
      endcase
      for (int i = 0; i < run_len; i++) begin
        s = level + $urandom_range(0, 40) - 20;
        if (s < 0) s = 0;
        if (s > altw_pkg::SAMPLE_MAX) s = altw_pkg::SAMPLE_MAX;
        send_sample(altw_pkg::sample_t'(s));
      end
      if (run == 5 || $urandom_range(0, 3) == 0) wait_results_drained();
    end
  endtask

  task automatic test_noise();
    for (int i = 0; i < 120; i++) begin
      if (i % 30 == 0) set_pacing($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0: send_sample(altw_pkg::sample_t'(altw_pkg::SAMPLE_MAX));
        1: send_sample(12'd0);
        default: send_sample(altw_pkg::sample_t'($urandom_range(0, altw_pkg::SAMPLE_MAX)));
      endcase
    end
  endtask

  // Result side: draws a stall after each result it takes and checks each result.
  initial begin
    int unsigned rx_hold;
    reading_t    want;
    rx_hold   = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        readings_seen++;
        if (pending_readings.size() == 0) begin
          err_count++;
          $display("%0t: unexpected item: height %0d mean %0d baseline_set %0b", $time,
                   out_height_percent, out_mean_level, out_baseline_set);
        end else begin
          want = pending_readings.pop_front();
          if (out_height_percent !== want.height_percent) begin
            err_count++;
            $display("%0t: height_percent expected %0d actual %0d", $time,
                     want.height_percent, out_height_percent);
          end
          if (out_mean_level !== want.mean_level) begin
            err_count++;
            $display("%0t: mean_level expected %0d actual %0d", $time,
                     want.mean_level, out_mean_level);
          end
          if (out_baseline_set !== want.baseline_set) begin
            err_count++;
            $display("%0t: baseline_set expected %0b actual %0b", $time,
                     want.baseline_set, out_baseline_set);
          end
        end
        rx_hold = $urandom_range(0, rx_stall_max);
      end
      if (rx_hold != 0) begin
        out_ready <= 1'b0;
        rx_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    for (int i = 0; i < altw_pkg::WINDOW; i++) window_buf[i] = '0;
    window_pos      = 0;
    window_total    = 0;
    baseline_mem    = '0;
    held_height     = '0;
    err_count       = 0;
    samples_sent    = 0;
    readings_seen   = 0;
    nonzero_heights = 0;
    over_baseline   = 0;
    tx_gap_max      = 0;
    rx_stall_max    = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_sample <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_startup();
    test_extremes();
    test_level_runs();
    test_noise();
    wait_results_drained();
    repeat (8) @(posedge clk);
    $display("Sent %0d samples and checked %0d results, baseline %0d.", samples_sent,
             readings_seen, baseline_mem);
    $display("Heights above zero: %0d, means over the baseline: %0d.", nonzero_heights,
             over_baseline);
    if (err_count == 0 && pending_readings.size() == 0) begin
      $display("[altitude_window_average] OK");
    end else begin
      $display("[altitude_window_average] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out with %0d results outstanding.", pending_readings.size());
    $display("[altitude_window_average] ERROR");
    $finish;
  end

endmodule

>>> files.f
rtl/altw_pkg.sv
rtl/altw_cell.sv
rtl/altw_mean.sv
rtl/altw_height.sv
rtl/altitude_window_average.sv
rtl/altw_checker.sv
tb/tb.sv
